// ----- hdl/fir18_pkg.sv -----
// fir18_pkg: widths and fixed q15 coefficients of the 18-tap low-pass filter
// no dependencies; imported by every module of the filter
package fir18_pkg;

  localparam int TAPS     = 18;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 14;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 32;
  localparam int FRAC_W   = 15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // coefficient k applies to x[n-k]
  localparam coef_t COEFS [TAPS] = '{
    coef_t'(-2033), coef_t'(-212), coef_t'(219),  coef_t'(944),  coef_t'(1889),
    coef_t'(2932),  coef_t'(3915), coef_t'(4681), coef_t'(5099), coef_t'(5099),
    coef_t'(4681),  coef_t'(3915), coef_t'(2932), coef_t'(1889), coef_t'(944),
    coef_t'(219),   coef_t'(-212), coef_t'(-2033)
  };

endpackage

// ----- hdl/fir_lowpass_18_tap_unit.sv -----
// fir_lowpass_18_tap_unit: 18-tap symmetric q15 low-pass fir, transposed form
// depends on fir18_pkg, fir18_cell, fir18_out
//
// usage:
//   input channel in_valid/in_ready/in_sample_in carries one signed 16-bit
//   sample per item; output channel out_valid/out_ready/out_sample_out carries
//   one filtered sample per input item, rounded half to even and wrapped.
//   latency: the result of an item is valid in the cycle after it is accepted.
//   throughput: one item per clock unless the output register is stalled; each of
//   the 17 cells does one multiply and add on the broadcast sample and hands its
//   partial sum to its neighbor. the chain of cells advances only when an item is accepted.
//   reset (rst_n low, synchronous) clears all partial sums, which equals an
//   all-zero history, and empties the output register.
//   stall: the output register holds its item while out_ready is low;
//   in_ready is high whenever that register is empty or being drained,
//   so a new item is taken in the same cycle the old result leaves.
module fir_lowpass_18_tap_unit
  import fir18_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_sample_in,
  output logic    out_valid,
  input  logic    out_ready,
  output sample_t out_sample_out
);

  logic in_accept;
  acc_t sum_w [1:TAPS];

  assign in_ready   = !out_valid || out_ready;
  assign in_accept  = in_valid && in_ready;
  assign sum_w[TAPS] = '0;

  for (genvar k = 1; k < TAPS; k++) begin : g_cell
    fir18_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (in_accept),
      .x      (in_sample_in),
      .coef   (COEFS[k]),
      .sum_in (sum_w[k+1]),
      .sum_r  (sum_w[k])
    );
  end

  fir18_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (in_accept),
    .out_ready   (out_ready),
    .x           (in_sample_in),
    .coef        (COEFS[0]),
    .sum_in      (sum_w[1]),
    .out_valid_r (out_valid),
    .sample_r    (out_sample_out)
  );

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output register");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid)
    else $error("accepted item produced no result");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out))
    else $error("result changed while stalled");

  a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(sum_w[1]) && $stable(sum_w[TAPS-1]))
    else $error("cell chain moved without an accepted item");

endmodule

// ----- hdl/fir18_cell.sv -----
// fir18_cell: one transposed-form tap, holds a partial sum and passes it on
// depends on fir18_pkg
module fir18_cell
  import fir18_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  sample_t x,
  input  coef_t   coef,
  input  acc_t    sum_in,
  output acc_t    sum_r
);

  prod_t prod;
  acc_t  sum_nxt;

  assign prod    = PROD_W'(coef) * PROD_W'(x);
  assign sum_nxt = ACC_W'(prod) + sum_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (en) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

// ----- hdl/fir18_out.sv -----
// fir18_out: head tap, round half to even from q15, output register
// depends on fir18_pkg
module fir18_out
  import fir18_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    out_ready,
  input  sample_t x,
  input  coef_t   coef,
  input  acc_t    sum_in,
  output logic    out_valid_r,
  output sample_t sample_r
);

  localparam logic [FRAC_W-1:0] HALF = FRAC_W'(1) << (FRAC_W - 1);

  prod_t             prod;
  acc_t              acc;
  logic [FRAC_W-1:0] frac;
  logic              up;
  sample_t           sample_nxt;
  logic              out_valid_nxt;

  assign prod       = PROD_W'(coef) * PROD_W'(x);
  assign acc        = ACC_W'(prod) + sum_in;
  assign frac       = acc[FRAC_W-1:0];
  assign up         = (frac > HALF) || ((frac == HALF) && acc[FRAC_W]);
  assign sample_nxt = acc[FRAC_W+SAMPLE_W-1:FRAC_W] + SAMPLE_W'(up);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_r <= sample_nxt;
    end
  end

endmodule

// ----- tb/tb_fir_lowpass_18_tap_unit.sv -----
// tb_fir_lowpass_18_tap_unit: self-checking bench for the 18-tap q15 low-pass fir unit
// depends on fir18_pkg and fir_lowpass_18_tap_unit; random stalls on both handshakes,
// expected samples come from an in-bench direct-form model of the filter
module tb_fir_lowpass_18_tap_unit;
  import fir18_pkg::*;

  localparam int  HIST_D     = 17;
  localparam int  WDOG_LIMIT = 2000;
  localparam int  N_FEED     = 924;
  localparam longint FIR_COEF [18] = '{
    -2033, -212, 219, 944, 1889, 2932, 3915, 4681, 5099,
    5099, 4681, 3915, 2932, 1889, 944, 219, -212, -2033
  };

  typedef struct {
    sample_t smp;
    bit      drain;
  } feed_item_t;

  logic    clk;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  sample_t in_sample_in = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  sample_t out_sample_out;

  feed_item_t sample_feed_q [$];
  sample_t    filt_expect_q [$];
  sample_t    filt_hist [HIST_D];
  int         n_errors = 0;
  int         n_taken = 0;
  bit         hold_req = 1'b0;

  fir_lowpass_18_tap_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic sample_t filt_predict(sample_t x);
    longint acc;
    longint q;
    longint frac;
    int     k;
    acc = FIR_COEF[0] * longint'(x);
    for (k = 0; k < HIST_D; k++) acc += FIR_COEF[k+1] * longint'(filt_hist[k]);
    q    = acc >>> 15;
    frac = acc & 64'h7fff;
    if (frac > 64'h4000 || (frac == 64'h4000 && q[0])) q = q + 1;
    for (k = HIST_D - 1; k > 0; k--) filt_hist[k] = filt_hist[k-1];
    filt_hist[0] = x;
    return sample_t'(q[15:0]);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 40);
  endfunction

  task automatic feed(sample_t s, bit drain = 1'b0);
    feed_item_t it;
    it.smp   = s;
    it.drain = drain;
    sample_feed_q.push_back(it);
  endtask

  // driver
  int tx_gap = 0;
  int tx_mode_left = 0;
  bit tx_calm = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_sample_in <= '0;
    end else begin
      if (in_valid && in_ready) begin
        filt_expect_q.push_back(filt_predict(in_sample_in));
        n_taken++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (sample_feed_q.size() > 0 &&
                     !(sample_feed_q[0].drain && filt_expect_q.size() != 0)) begin
          in_valid     <= 1'b1;
          in_sample_in <= sample_feed_q[0].smp;
          sample_feed_q.pop_front();
          if (tx_mode_left == 0) begin
            tx_calm      = ($urandom_range(0, 3) == 0);
            tx_mode_left = $urandom_range(20, 100);
          end
          tx_mode_left--;
          tx_gap = tx_calm ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int rx_stall = 0;
  int rx_mode_left = 0;
  bit rx_calm = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (filt_expect_q.size() == 0) begin
          $error("unexpected item: sample_out actual %0d", out_sample_out);
          n_errors++;
        end else begin
          if (out_sample_out !== filt_expect_q[0]) begin
            $error("sample_out expected %0d actual %0d", filt_expect_q[0], out_sample_out);
            n_errors++;
          end
          filt_expect_q.pop_front();
        end
      end
      if (rx_mode_left == 0) begin
        rx_calm      = ($urandom_range(0, 3) == 0);
        rx_mode_left = $urandom_range(20, 120);
      end
      rx_mode_left--;
      if (hold_req) begin
        hold_req = 1'b0;
        rx_stall = 80;
      end else if (rx_stall == 0 && !rx_calm && $urandom_range(0, 3) == 0) begin
        rx_stall = pick_gap();
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int      i;
    int      kind;
    int      len;
    int      next_drain;
    bit      first;
    sample_t v;
    for (i = 0; i < HIST_D; i++) filt_hist[i] = '0;

    // exact halves on a zero history, unit steps, extremes, then wrap on a full run
    feed(sample_t'(16384));
    feed(sample_t'(-16384));
    feed(sample_t'(1));
    feed(sample_t'(-1));
    feed(sample_t'(0));
    feed(sample_t'(-32768));
    for (i = 0; i < 18; i++) feed(sample_t'(32767));

    next_drain = sample_feed_q.size();
    while (sample_feed_q.size() < N_FEED) begin
      kind  = $urandom_range(0, 9);
      first = (sample_feed_q.size() >= next_drain);
      if (first) next_drain = sample_feed_q.size() + $urandom_range(120, 200);
      case (kind)
        0, 1, 2, 3: begin
          len = $urandom_range(8, 30);
          for (i = 0; i < len; i++) feed(sample_t'($urandom()), first && i == 0);
        end
        4: begin
          len = $urandom_range(8, 30);
          for (i = 0; i < len; i++)
            feed(sample_t'($urandom_range(0, 255) - 128), first && i == 0);
        end
        5: begin
          v = $urandom_range(0, 1) ? sample_t'(32767) : sample_t'(-32768);
          len = $urandom_range(18, 24);
          for (i = 0; i < len; i++) feed(v, first && i == 0);
        end
        6: begin
          for (i = 0; i < HIST_D; i++) feed(sample_t'(0), first && i == 0);
          feed($urandom_range(0, 1) ? sample_t'(16384) : sample_t'(-16384));
          len = $urandom_range(0, 4);
          for (i = 0; i < len; i++) feed(sample_t'($urandom()));
        end
        7: begin
          for (i = 0; i < 18; i++)
            feed(i[0] ? sample_t'(-32768) : sample_t'(32767), first && i == 0);
        end
        8: begin
          v = $urandom_range(0, 1) ? sample_t'(32767) : sample_t'(-32768);
          feed(v, first);
          for (i = 0; i < HIST_D; i++) feed(sample_t'(0));
        end
        default: begin
          v = sample_t'($urandom());
          for (i = 0; i < 18; i++) feed(v, first && i == 0);
        end
      endcase
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_taken >= 300);
    @(negedge clk);
    hold_req = 1'b1;

    while (sample_feed_q.size() != 0 || in_valid) @(posedge clk);
    while (filt_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (n_errors == 0 && filt_expect_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
